### design/dsd_pkg.sv
package dsd_pkg;

  localparam int unsigned ValueWidth = 24;
  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_LARGE = 2'd1,
    ERR_NEGATIVE  = 2'd2
  } err_e;

  // how many integer digits the value shows
  typedef enum logic [1:0] {
    RNG_UNITS     = 2'd0,
    RNG_TENS      = 2'd1,
    RNG_HUNDREDS  = 2'd2,
    RNG_THOUSANDS = 2'd3
  } rng_e;

  localparam logic [CfgIdxWidth-1:0] CFG_LAST_DOT  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_LEAD_ZERO = 2'd1;

  // bounds in thousandths
  localparam logic [23:0] TOO_LARGE_LIMIT = 24'd10000000;
  localparam logic [22:0] THOUSAND_LIMIT  = 23'd1000000;
  localparam logic [22:0] HUNDRED_LIMIT   = 23'd100000;
  localparam logic [22:0] TEN_LIMIT       = 23'd10000;

  // reciprocals, exact for any 32-bit dividend
  localparam logic [31:0] RECIP_1000 = 32'h10624DD3;  // shift 38
  localparam logic [31:0] RECIP_100  = 32'h51EB851F;  // shift 37
  localparam logic [31:0] RECIP_10   = 32'hCCCCCCCD;  // shift 35

  localparam logic [13:0] MAX_FOUR  = 14'd9999;
  localparam logic [13:0] MAX_THREE = 14'd999;

  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

### design/decimal_to_seven_segment_digits.sv
// path: stages 1, 2, 3 and 4 (4-stage pipeline) feed the output stage; en low
// holds them all. throughput: one output beat per cycle while m_axis_tready_i
// is high; an item gives 1, 3 or 4 beats, and the input side takes one item per
// cycle only while the output stage is empty or its last beat is being taken
// reset: asynchronous active low, clears all valid flags and both config bits
module decimal_to_seven_segment_digits (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dsd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic                             cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [dsd_pkg::ValueWidth-1:0]   s_axis_tdata_i,   // [23:0] value_thousandths
  // output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [1:0] digit_position, [5:2] digit_select_n, [12:6] segments, [13] dot, [15:14] zero
  output logic [15:0]                      m_axis_tdata_o,
  output logic [1:0]                       m_axis_tuser_o,   // [1:0] error_code
  output logic                             m_axis_tlast_o
);
  import dsd_pkg::*;

  logic last_dot_q, lead_zero_q;

  logic en;

  // stage 1: input register
  logic        v1_q;
  logic [23:0] val1_q;

  // stage 2: quotient by the range divisor
  logic        v2_q;
  logic [22:0] u2_q;
  logic [19:0] q2_q;
  rng_e        rng2_q;
  err_e        err2_q;

  // stage 3: rounded and clamped shown number
  logic        v3_q;
  logic [13:0] n3_q;
  rng_e        rng3_q;
  err_e        err3_q;

  // stage 4: partial quotients for the digit split
  logic        v4_q;
  logic [13:0] n4_q;
  logic [3:0]  q1000_4_q;
  logic [6:0]  q100_4_q;
  logic [9:0]  q10_4_q;
  rng_e        rng4_q;
  err_e        err4_q;

  // output stage
  logic        bv_q;
  logic [1:0]  pos_q;
  err_e        err_q;
  logic [6:0]  seg_q [4];
  logic [3:0]  dot_q;

  logic out_last;
  logic out_err;

  assign out_err  = (err_q != ERR_NONE);
  assign out_last = out_err || (pos_q == 2'd3);
  assign en       = !bv_q || (m_axis_tready_i && out_last);

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = en;

  // ---------------- stage 2 logic
  logic [22:0] u1;
  rng_e        rng1;
  err_e        err1;
  logic [31:0] recip1;
  logic [54:0] prod1;
  logic [19:0] q1;

  always_comb begin
    u1 = val1_q[22:0];
    if (val1_q[23]) begin
      err1 = ERR_NEGATIVE;
    end else if ({1'b0, u1} >= TOO_LARGE_LIMIT) begin
      err1 = ERR_TOO_LARGE;
    end else begin
      err1 = ERR_NONE;
    end
    if (u1 >= THOUSAND_LIMIT) begin
      rng1 = RNG_THOUSANDS;
    end else if (u1 >= HUNDRED_LIMIT) begin
      rng1 = RNG_HUNDREDS;
    end else if (u1 >= TEN_LIMIT) begin
      rng1 = RNG_TENS;
    end else begin
      rng1 = RNG_UNITS;
    end
    case (rng1)
      RNG_THOUSANDS: recip1 = RECIP_1000;
      RNG_HUNDREDS:  recip1 = RECIP_100;
      default:       recip1 = RECIP_10;
    endcase
    prod1 = 55'(u1) * 55'(recip1);
    case (rng1)
      RNG_THOUSANDS: q1 = 20'(prod1[54:38]);
      RNG_HUNDREDS:  q1 = 20'(prod1[54:37]);
      default:       q1 = prod1[54:35];
    endcase
  end

  // ---------------- stage 3 logic
  logic [22:0] div2;
  logic [22:0] qd2;
  logic [22:0] rem_full2;
  logic [9:0]  rem2;
  logic        inc2;
  logic [20:0] sum2;
  logic [13:0] maxn2;
  logic [13:0] n2;

  always_comb begin
    case (rng2_q)
      RNG_THOUSANDS: div2 = 23'd1000;
      RNG_HUNDREDS:  div2 = 23'd100;
      default:       div2 = 23'd10;
    endcase
    qd2       = 23'(q2_q) * div2;
    rem_full2 = u2_q - qd2;
    rem2      = rem_full2[9:0];
    // round up only when the dropped part is above one half; thousands never round up
    case (rng2_q)
      RNG_THOUSANDS: inc2 = 1'b0;
      RNG_HUNDREDS:  inc2 = (rem2 > 10'd50);
      default:       inc2 = (rem2 > 10'd5);
    endcase
    sum2  = 21'(q2_q) + 21'(inc2);
    maxn2 = (rng2_q == RNG_UNITS) ? MAX_THREE : MAX_FOUR;
    // carry out of the shown digits saturates them at nine
    n2 = (sum2 > 21'(maxn2)) ? maxn2 : sum2[13:0];
  end

  // ---------------- stage 4 logic
  logic [26:0] p1000_3;
  logic [25:0] p100_3;
  logic [29:0] p10_3;

  always_comb begin
    p1000_3 = 27'(n3_q) * 27'd8389;
    p100_3  = 26'(n3_q) * 26'd5243;
    p10_3   = 30'(n3_q) * 30'd52429;
  end

  // ---------------- output stage load logic
  logic [3:0]  dig4 [4];
  logic [6:0]  d1_full4;
  logic [9:0]  d2_full4;
  logic [13:0] d3_full4;
  logic [1:0]  dot_pos4;
  logic [3:0]  dot4;
  logic [1:0]  first4;
  logic [6:0]  seg4 [4];

  always_comb begin
    d1_full4 = q100_4_q - 7'(q1000_4_q) * 7'd10;
    d2_full4 = q10_4_q - 10'(q100_4_q) * 10'd10;
    d3_full4 = n4_q - 14'(q10_4_q) * 14'd10;
    dig4[0]  = q1000_4_q;
    dig4[1]  = d1_full4[3:0];
    dig4[2]  = d2_full4[3:0];
    dig4[3]  = d3_full4[3:0];
    for (int i = 0; i < 4; i++) begin
      seg4[i] = (err4_q != ERR_NONE) ? 7'h00 : seg_of(dig4[i]);
    end
    case (rng4_q)
      RNG_THOUSANDS: dot_pos4 = 2'd3;
      RNG_HUNDREDS:  dot_pos4 = 2'd2;
      default:       dot_pos4 = 2'd1;
    endcase
    dot4 = 4'b0001 << dot_pos4;
    if ((err4_q != ERR_NONE) || ((rng4_q == RNG_THOUSANDS) && !last_dot_q)) begin
      dot4 = 4'b0000;
    end
    // small values skip the leftmost position unless a leading zero is wanted
    if ((err4_q == ERR_NONE) && (rng4_q == RNG_UNITS) && !lead_zero_q) begin
      first4 = 2'd1;
    end else begin
      first4 = 2'd0;
    end
  end

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dot_q  <= 1'b0;
      lead_zero_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      bv_q        <= 1'b0;
      pos_q       <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LAST_DOT:  last_dot_q  <= cfg_data_i;
          CFG_LEAD_ZERO: lead_zero_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (en) begin
        v1_q <= s_axis_tvalid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        bv_q <= v4_q;
        pos_q <= first4;
      end else if (m_axis_tready_i) begin
        // bv_q is set here, otherwise en would be high
        pos_q <= pos_q + 2'd1;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      val1_q    <= s_axis_tdata_i;
      u2_q      <= u1;
      q2_q      <= q1;
      rng2_q    <= rng1;
      err2_q    <= err1;
      n3_q      <= n2;
      rng3_q    <= rng2_q;
      err3_q    <= err2_q;
      n4_q      <= n3_q;
      q1000_4_q <= p1000_3[26:23];
      q100_4_q  <= p100_3[25:19];
      q10_4_q   <= p10_3[28:19];
      rng4_q    <= rng3_q;
      err4_q    <= err3_q;
      err_q     <= err4_q;
      dot_q     <= dot4;
      for (int i = 0; i < 4; i++) begin
        seg_q[i] <= seg4[i];
      end
    end
  end

  // ---------------- output beat
  logic [1:0] out_pos;
  logic [3:0] out_sel_n;
  logic [6:0] out_seg;
  logic       out_dot;

  always_comb begin
    out_pos   = out_err ? 2'd0 : pos_q;
    out_sel_n = out_err ? 4'hF : ~(4'b0001 << pos_q);
    out_seg   = seg_q[out_pos];
    out_dot   = dot_q[out_pos];
  end

  assign m_axis_tvalid_o = bv_q;
  assign m_axis_tdata_o  = {2'b00, out_dot, out_seg, out_sel_n, out_pos};
  assign m_axis_tuser_o  = err_q;
  assign m_axis_tlast_o  = out_last;

endmodule
